@@ hdl/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion, checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/sas_pkg.sv @@
// ----------------------------------------------------------------------------
// sas_pkg
// Types and constants for the shell argument splitter.
// ----------------------------------------------------------------------------
package sas_pkg;

    typedef enum logic [1:0] {
        EV_START  = 2'd0,
        EV_APPEND = 2'd1,
        EV_END    = 2'd2,
        EV_EOI    = 2'd3
    } t_event_kind;

    typedef struct packed {
        t_event_kind kind;
        logic [7:0]  data;
        logic        last;
    } t_event;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    localparam logic [7:0] MAX_ARGS_RESET = 8'd255;
    localparam logic [7:0] ARG_COUNT_MAX  = 8'd255;

    // Event queue
    localparam int unsigned EVQ_DEPTH = 4;
    localparam int unsigned EVQ_AW    = $clog2(EVQ_DEPTH);
    localparam int unsigned EVQ_CW    = $clog2(EVQ_DEPTH + 1);

endpackage

@@ hdl/shell_argument_splitter_core.sv @@
// ----------------------------------------------------------------------------
// shell_argument_splitter_core
// A taken byte's events are registered in the event queue and offered from its head.
// Throughput: one byte per cycle while o_stall is low; a byte that gives two
//   events takes two queue entries, the four-entry event queue absorbs the burst.
// Reset (synchronous, active low): searching mode, queue empty, cap 255.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shell_argument_splitter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_event_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last_event
);

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_PLAIN  = 2'd1,
        MODE_DOUBLE = 2'd2,
        MODE_SINGLE = 2'd3
    } t_mode;

    t_mode      r_mode, n_mode;
    logic       r_escape, n_escape;
    logic [7:0] r_arg_count, n_arg_count;
    logic       r_capped, n_capped;
    logic [7:0] r_max_args;

    sas_pkg::t_event r_evq [sas_pkg::EVQ_DEPTH];
    logic [sas_pkg::EVQ_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [sas_pkg::EVQ_CW-1:0] r_count, n_count;

    sas_pkg::t_event ev0, ev1;
    logic [1:0]      num_ev;
    logic            in_acc, out_acc;
    logic [7:0]      esc_byte;
    t_mode           qmode;
    logic            is_ws;

    assign o_stall = (r_count > sas_pkg::EVQ_CW'(sas_pkg::EVQ_DEPTH - 2));
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = (r_count != '0);
    assign out_acc = o_valid && !i_stall;

    assign o_event_kind = r_evq[r_rd_ptr].kind;
    assign o_out_byte   = r_evq[r_rd_ptr].data;
    assign o_last_event = r_evq[r_rd_ptr].last;

    always_comb begin
        case (i_in_byte)
            sas_pkg::CH_N: esc_byte = sas_pkg::CH_LF;
            sas_pkg::CH_R: esc_byte = sas_pkg::CH_CR;
            sas_pkg::CH_T: esc_byte = sas_pkg::CH_TAB;
            default:       esc_byte = i_in_byte;
        endcase
        qmode = (i_in_byte == sas_pkg::CH_SQUOTE) ? MODE_SINGLE : MODE_DOUBLE;
        is_ws = i_in_byte inside {sas_pkg::CH_SPACE, sas_pkg::CH_TAB,
                                  sas_pkg::CH_LF, sas_pkg::CH_CR};
    end

    // Parse step: state update and up to two events
    always_comb begin
        n_mode      = r_mode;
        n_escape    = r_escape;
        n_arg_count = r_arg_count;
        n_capped    = r_capped;
        num_ev      = 2'd0;
        ev0         = '{kind: sas_pkg::EV_START, data: 8'd0, last: 1'b0};
        ev1         = '{kind: sas_pkg::EV_APPEND, data: 8'd0, last: 1'b1};

        if (i_in_byte == sas_pkg::CH_NUL) begin
            if (r_mode != MODE_SEARCH) begin
                ev0.kind = sas_pkg::EV_END;
                ev1.kind = sas_pkg::EV_EOI;
                num_ev   = 2'd2;
            end else begin
                ev0.kind = sas_pkg::EV_EOI;
                num_ev   = 2'd1;
            end
            n_mode      = MODE_SEARCH;
            n_escape    = 1'b0;
            n_arg_count = 8'd0;
            n_capped    = 1'b0;
        end else if (r_escape) begin
            n_escape = 1'b0;
            ev0.kind = sas_pkg::EV_APPEND;
            ev0.data = esc_byte;
            num_ev   = 2'd1;
        end else if (r_capped || (r_arg_count >= r_max_args)) begin
            n_capped = 1'b1;
        end else if ((i_in_byte == sas_pkg::CH_SQUOTE) ||
                     (i_in_byte == sas_pkg::CH_DQUOTE)) begin
            if (r_mode == MODE_SEARCH) begin
                n_mode = qmode;
                num_ev = 2'd1;
            end else if (r_mode == qmode) begin
                n_mode = MODE_PLAIN;
            end else if (r_mode == MODE_PLAIN) begin
                n_mode = qmode;
            end else begin
                ev0.kind = sas_pkg::EV_APPEND;
                ev0.data = i_in_byte;
                num_ev   = 2'd1;
            end
        end else if (is_ws) begin
            if (r_mode == MODE_PLAIN) begin
                ev0.kind = sas_pkg::EV_END;
                n_mode   = MODE_SEARCH;
                num_ev   = 2'd1;
            end else if (r_mode != MODE_SEARCH) begin
                ev0.kind = sas_pkg::EV_APPEND;
                ev0.data = i_in_byte;
                num_ev   = 2'd1;
            end
        end else if (i_in_byte == sas_pkg::CH_BSLASH) begin
            if (r_mode == MODE_SEARCH) begin
                n_mode = MODE_PLAIN;
                num_ev = 2'd1;
            end
            n_escape = 1'b1;
        end else begin
            if (r_mode == MODE_SEARCH) begin
                n_mode   = MODE_PLAIN;
                ev1.data = i_in_byte;
                num_ev   = 2'd2;
            end else begin
                ev0.kind = sas_pkg::EV_APPEND;
                ev0.data = i_in_byte;
                num_ev   = 2'd1;
            end
        end

        // argument start counts, saturating
        if ((i_in_byte != sas_pkg::CH_NUL) && (num_ev != 2'd0) &&
            (ev0.kind == sas_pkg::EV_START) &&
            (r_arg_count != sas_pkg::ARG_COUNT_MAX)) begin
            n_arg_count = r_arg_count + 8'd1;
        end
        ev0.last = (num_ev == 2'd1);
    end

    always_comb begin
        n_count = r_count;
        if (in_acc) begin
            n_count = n_count + sas_pkg::EVQ_CW'(num_ev);
        end
        if (out_acc) begin
            n_count = n_count - sas_pkg::EVQ_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SEARCH;
            r_escape    <= 1'b0;
            r_arg_count <= 8'd0;
            r_capped    <= 1'b0;
            r_max_args  <= sas_pkg::MAX_ARGS_RESET;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max_args <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_mode      <= n_mode;
                r_escape    <= n_escape;
                r_arg_count <= n_arg_count;
                r_capped    <= n_capped;
                r_wr_ptr    <= r_wr_ptr + sas_pkg::EVQ_AW'(num_ev);
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + sas_pkg::EVQ_AW'(1);
            end
            r_count <= n_count;
        end
    end

    // Event queue storage
    always_ff @(posedge i_clk) begin
        if (in_acc && (num_ev != 2'd0)) begin
            r_evq[r_wr_ptr] <= ev0;
        end
        if (in_acc && (num_ev == 2'd2)) begin
            r_evq[r_wr_ptr + sas_pkg::EVQ_AW'(1)] <= ev1;
        end
    end

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n,
        r_count <= sas_pkg::EVQ_CW'(sas_pkg::EVQ_DEPTH), "event queue overflow")
    `ASSERT_CLK(a_eoi_last, i_clk, i_rst_n,
        o_valid && (o_event_kind == sas_pkg::EV_EOI) |-> o_last_event,
        "end of input not marked last")
    `ASSERT_CLK(a_byte_zero, i_clk, i_rst_n,
        o_valid && (o_event_kind != sas_pkg::EV_APPEND) |-> (o_out_byte == 8'd0),
        "non-append event carries a byte")
    `ASSERT_CLK(a_nul_reset, i_clk, i_rst_n,
        in_acc && (i_in_byte == sas_pkg::CH_NUL) |=> (r_mode == MODE_SEARCH) &&
        (r_arg_count == 8'd0) && !r_capped && !r_escape,
        "end of string did not clear parse state")
    `ASSERT_CLK(a_escape_mode, i_clk, i_rst_n,
        r_escape |-> (r_mode != MODE_SEARCH), "escape pending outside an argument")

endmodule
